>>> hw/rtl/aes_pkg.sv
package aes_pkg;

	typedef struct packed {
		logic        cmd;
		logic [63:0] block_high;
		logic [63:0] block_low;
	} aes_in_t;

	typedef struct packed {
		logic [63:0] result_high;
		logic [63:0] result_low;
	} aes_out_t;

	localparam logic CMD_ENC = 1'b0;
	localparam logic CMD_DEC = 1'b1;

	localparam logic CFG_KEY_HIGH = 1'b0;
	localparam logic CFG_KEY_LOW  = 1'b1;

	localparam int NUM_ROUNDS = 10;

	localparam logic [7:0] FWD_BOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] INV_BOX [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	localparam logic [7:0] RCON [10] = '{
		8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
	};

	function automatic logic [7:0] xt(input logic [7:0] b);
		xt = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	// Next round key in the forward schedule.
	function automatic logic [127:0] key_next(input logic [127:0] k, input logic [7:0] rc);
		logic [31:0] t;
		logic [31:0] w0, w1, w2, w3;
		t = {FWD_BOX[k[23:16]], FWD_BOX[k[15:8]], FWD_BOX[k[7:0]], FWD_BOX[k[31:24]]};
		t = t ^ {rc, 24'h0};
		w0 = k[127:96] ^ t;
		w1 = k[95:64] ^ w0;
		w2 = k[63:32] ^ w1;
		w3 = k[31:0] ^ w2;
		key_next = {w0, w1, w2, w3};
	endfunction

	// Byte i of the block sits at bits 127-8i.
	function automatic logic [7:0] byte_at(input logic [127:0] s, input int i);
		byte_at = s[127 - 8*i -: 8];
	endfunction

	function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
		logic [127:0] t;
		logic [127:0] m;
		logic [7:0] a0, a1, a2, a3;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[127 - 8*(4*c + r) -: 8] = FWD_BOX[byte_at(s, 4*((c + r) % 4) + r)];
			end
		end
		for (int c = 0; c < 4; c++) begin
			a0 = byte_at(t, 4*c);
			a1 = byte_at(t, 4*c + 1);
			a2 = byte_at(t, 4*c + 2);
			a3 = byte_at(t, 4*c + 3);
			m[127 - 8*(4*c) -: 8]     = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
			m[127 - 8*(4*c + 1) -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
			m[127 - 8*(4*c + 2) -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
			m[127 - 8*(4*c + 3) -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
		end
		enc_round = last ? t : m;
	endfunction

	function automatic logic [127:0] inv_mix(input logic [127:0] s);
		logic [127:0] m;
		logic [7:0] a [4];
		logic [7:0] x2 [4];
		logic [7:0] x4 [4];
		logic [7:0] x8 [4];
		logic [7:0] e [4];
		logic [7:0] b [4];
		logic [7:0] d [4];
		logic [7:0] n [4];
		for (int c = 0; c < 4; c++) begin
			for (int j = 0; j < 4; j++) begin
				a[j] = byte_at(s, 4*c + j);
				x2[j] = xt(a[j]);
				x4[j] = xt(x2[j]);
				x8[j] = xt(x4[j]);
				e[j] = x8[j] ^ x4[j] ^ x2[j];
				b[j] = x8[j] ^ x2[j] ^ a[j];
				d[j] = x8[j] ^ x4[j] ^ a[j];
				n[j] = x8[j] ^ a[j];
			end
			for (int r = 0; r < 4; r++) begin
				m[127 - 8*(4*c + r) -: 8] = e[r] ^ b[(r + 1) % 4] ^ d[(r + 2) % 4]
					^ n[(r + 3) % 4];
			end
		end
		inv_mix = m;
	endfunction

	function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
		logic [127:0] t;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[127 - 8*(4*((c + r) % 4) + r) -: 8] = INV_BOX[byte_at(s, 4*c + r)];
			end
		end
		inv_shift_sub = t;
	endfunction

endpackage

>>> hw/rtl/aes_key_cell.sv
// One step of the key schedule: expands the key for the next round while it travels.
module aes_key_cell import aes_pkg::*; #(
	parameter int RCON_IDX = 0
) (
	input  logic         clk,
	input  logic [127:0] key_in,
	output logic [127:0] key_out
);
	always_ff @(posedge clk) begin
		key_out <= key_next(key_in, RCON[RCON_IDX]);
	end
endmodule

>>> hw/rtl/aes_round_cell.sv
// One round cell: holds one item in flight and hands it on every cycle.
// Encryption cells run rounds forward; decryption uses the mirrored round
// order, so decryption needs all round keys in advance; each cell takes them from the key schedule chain.
module aes_round_cell import aes_pkg::*; #(
	parameter int ROUND = 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         vld_in,
	input  logic         cmd_in,
	input  logic [127:0] st_in,
	input  logic [127:0] enc_key,
	input  logic [127:0] dec_key,
	output logic         vld_out,
	output logic         cmd_out,
	output logic [127:0] st_out
);
	localparam logic LAST = (ROUND == NUM_ROUNDS);

	logic [127:0] nxt;

	always_comb begin
		if (cmd_in == CMD_ENC) begin
			nxt = enc_round(st_in, LAST) ^ enc_key;
		end else if (LAST) begin
			nxt = inv_shift_sub(st_in) ^ dec_key;
		end else begin
			nxt = inv_mix(inv_shift_sub(st_in) ^ dec_key);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		cmd_out <= cmd_in;
		st_out <= nxt;
	end
endmodule

>>> hw/rtl/aes128_block_cipher_unit.sv
// Pipeline: one stage per round plus the whitening stage, from start to result strobe.
// Throughput: one item per cycle while busy is low; busy is high only after reset or a key write,
// while the new round keys ripple down the key schedule chain.
// Key writes are taken only while no item is in flight.
// Reset clears the key register to zero and empties the pipeline; the receiver cannot stall.
module aes128_block_cipher_unit import aes_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	input  aes_in_t      din,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_index,
	input  logic [63:0]  cfg_data,
	output logic         strobe,
	output aes_out_t     dout
);
	logic [127:0] key_q;
	logic [3:0]   settle_q;
	logic         in_flight;
	logic [127:0] rk [NUM_ROUNDS + 1];
	logic         vld [NUM_ROUNDS + 1];
	logic         cmd [NUM_ROUNDS + 1];
	logic [127:0] st [NUM_ROUNDS + 1];

	always_comb begin
		in_flight = 1'b0;
		for (int i = 0; i <= NUM_ROUNDS; i++) begin
			in_flight = in_flight | vld[i];
		end
	end

	assign busy = (settle_q != 4'd0);
	assign cfg_ready = !in_flight && !(start && !busy);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_KEY_HIGH: key_q[127:64] <= cfg_data;
				CFG_KEY_LOW:  key_q[63:0] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Inputs are held off until every round key reflects the current key.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= 4'(NUM_ROUNDS);
		end else if (cfg_valid && cfg_ready) begin
			settle_q <= 4'(NUM_ROUNDS);
		end else if (settle_q != 4'd0) begin
			settle_q <= settle_q - 4'd1;
		end
	end

	// Key schedule as a chain of cells; busy covers its settling after a write.
	assign rk[0] = key_q;
	for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_key
		aes_key_cell #(.RCON_IDX(g)) u_key (
			.clk(clk), .key_in(rk[g]), .key_out(rk[g + 1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld[0] <= 1'b0;
		end else begin
			vld[0] <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		cmd[0] <= din.cmd;
		st[0] <= {din.block_high, din.block_low}
			^ ((din.cmd == CMD_ENC) ? rk[0] : rk[NUM_ROUNDS]);
	end

	for (genvar g = 1; g <= NUM_ROUNDS; g++) begin : g_round
		aes_round_cell #(.ROUND(g)) u_round (
			.clk(clk), .arst_n(arst_n),
			.vld_in(vld[g - 1]), .cmd_in(cmd[g - 1]), .st_in(st[g - 1]),
			.enc_key(rk[g]), .dec_key(rk[NUM_ROUNDS - g]),
			.vld_out(vld[g]), .cmd_out(cmd[g]), .st_out(st[g])
		);
	end

	assign strobe = vld[NUM_ROUNDS];
	assign dout.result_high = st[NUM_ROUNDS][127:64];
	assign dout.result_low = st[NUM_ROUNDS][63:0];
endmodule
